>>> hw/rtl/i2d_pkg.sv
// Shared types and constants for the integer to decimal text converter.
// No dependencies; every other file but i2d_if imports this package.
package i2d_pkg;

  localparam int unsigned MAX_DIGITS = 10;

  localparam logic [6:0] ASCII_ZERO  = 7'd48;
  localparam logic [6:0] ASCII_MINUS = 7'd45;

  typedef logic [33:0] wide_t;
  typedef logic [3:0]  digit_pos_t;
  typedef logic [3:0]  char_cnt_t;

  // Multiples of powers of ten, indexed [position][digit]
  typedef logic [MAX_DIGITS-1:0][9:0][33:0] mult_tab_t;

  // Build the table once at elaboration
  function automatic mult_tab_t build_mult();
    mult_tab_t t;
    wide_t     p;
    p = 34'd1;
    for (int pos = 0; pos < MAX_DIGITS; pos++) begin
      for (int d = 0; d < 10; d++) begin
        t[pos][d] = wide_t'(p * 34'(d));
      end
      p = wide_t'(p * 34'd10);
    end
    return t;
  endfunction

  localparam mult_tab_t DEC_MULT = build_mult();

  // One classified value waiting for conversion
  typedef struct packed {
    logic        neg;
    digit_pos_t  ndig;
    logic [31:0] mag;
  } entry_t;

endpackage

>>> hw/rtl/i2d_if.sv
// Valid/ready channel interfaces for the input values and output characters.
// Depends on nothing, not even the package; plain payload widths.
interface i2d_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2d_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       is_last;
  logic [3:0] char_total;

  modport source (output valid, output char_code, output is_last, output char_total,
                  input ready);
  modport sink   (input valid, input char_code, input is_last, input char_total,
                  output ready);
endinterface

>>> hw/rtl/i2d_front.sv
// Front end: accepts a value, forms sign and magnitude, counts its digits.
// Depends on i2d_pkg and i2d_in_if.
module i2d_front (
  i2d_in_if.sink           in_ch,
  input  logic             q_ready,
  output logic             q_push,
  output i2d_pkg::entry_t  q_entry
);
  import i2d_pkg::*;

  logic                  neg;
  logic [31:0]           mag;
  logic [MAX_DIGITS-1:1] ge;

  // Take a value whenever the queue has room
  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid & q_ready;

  // Form the unsigned magnitude; the most negative value wraps to 2^31
  assign neg = in_ch.value[31];
  assign mag = neg ? (~in_ch.value + 32'd1) : in_ch.value;

  // Compare against each power of ten to find the digit count
  always_comb begin
    for (int k = 1; k < MAX_DIGITS; k++) begin
      ge[k] = {2'b00, mag} >= DEC_MULT[k][1];
    end
  end

  assign q_entry.neg  = neg;
  assign q_entry.mag  = mag;
  assign q_entry.ndig = digit_pos_t'($countones(ge)) + 4'd1;

endmodule

>>> hw/rtl/i2d_queue.sv
// Two-entry queue between the front end and the digit generator.
// Depends on i2d_pkg.
module i2d_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  i2d_pkg::entry_t  push_entry,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output i2d_pkg::entry_t  pop_entry
);
  import i2d_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = count_r != 2'd2;
  assign pop_valid  = count_r != 2'd0;
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hw/rtl/i2d_back.sv
// Back end: emits a minus sign for a negative value, then one decimal digit per
// cycle unless stalled, most significant first. Depends on i2d_pkg and i2d_out_if.
module i2d_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  i2d_pkg::entry_t  q_entry,
  output logic             q_pop,
  i2d_out_if.source        out_ch
);
  import i2d_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SIGN, S_DIGITS} state_t;

  state_t      state_r;
  logic [31:0] mag_r;
  digit_pos_t  pos_r;
  char_cnt_t   total_r;
  logic        out_valid_r;
  logic [6:0]  char_r;
  logic        last_r;
  char_cnt_t   out_total_r;

  logic        can_emit;
  logic        emit;
  logic [9:1]  ge;
  logic [3:0]  digit;
  wide_t       sub;
  logic [31:0] mag_nxt;

  // Output register free, or being emptied this cycle
  assign can_emit = !out_valid_r || out_ch.ready;
  assign emit     = can_emit && (state_r == S_SIGN || state_r == S_DIGITS);
  assign q_pop    = state_r == S_IDLE;

  // Pick the digit at the current position by parallel threshold compares
  always_comb begin
    for (int d = 1; d < 10; d++) begin
      ge[d] = {2'b00, mag_r} >= DEC_MULT[pos_r][d];
    end
  end

  assign digit   = 4'($countones(ge));
  assign sub     = DEC_MULT[pos_r][digit];
  assign mag_nxt = mag_r - sub[31:0];

  // Sequence one value and hold the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new character, or drop the one just taken
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            mag_r   <= q_entry.mag;
            pos_r   <= q_entry.ndig - 4'd1;
            total_r <= q_entry.ndig + {3'b000, q_entry.neg};
            state_r <= q_entry.neg ? S_SIGN : S_DIGITS;
          end
        end
        S_SIGN: begin
          if (can_emit) begin
            char_r      <= ASCII_MINUS;
            last_r      <= 1'b0;
            out_total_r <= total_r;
            state_r     <= S_DIGITS;
          end
        end
        S_DIGITS: begin
          if (can_emit) begin
            char_r      <= ASCII_ZERO + {3'b000, digit};
            last_r      <= pos_r == 4'd0;
            out_total_r <= total_r;
            mag_r       <= mag_nxt;
            if (pos_r == 4'd0) begin
              state_r <= S_IDLE;
            end else begin
              pos_r <= pos_r - 4'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.char_code  = char_r;
  assign out_ch.is_last    = last_r;
  assign out_ch.char_total = out_total_r;

endmodule

>>> hw/rtl/int32_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, one character per output transaction.
// A value of 1 to 11 characters is loaded by the digit generator, which then emits
// one character per cycle unless the output stalls; the queue accepts new values
// while the digit generator is busy, until both of its entries are full.
// Reset: synchronous, active low; empties the two-entry queue and drops the output.
// Depends on i2d_pkg, i2d_if, i2d_front, i2d_queue and i2d_back.
module int32_to_decimal_ascii (
  input  logic      clk,
  input  logic      rst_n,
  i2d_in_if.sink    in_ch,
  i2d_out_if.source out_ch
);
  import i2d_pkg::*;

  logic   q_push;
  logic   q_ready;
  entry_t q_in;
  logic   q_pop;
  logic   q_valid;
  entry_t q_out;

  i2d_front u_front (
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  i2d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_out)
  );

  i2d_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // Characters of one value leave without a gap once the first is taken
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.is_last |=> out_ch.valid)
    else $error("gap inside one value's text");

  // A minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.char_code == ASCII_MINUS |-> !out_ch.is_last)
    else $error("minus sign flagged as last character");

  // Only a minus sign or a decimal digit is emitted
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.char_code == ASCII_MINUS ||
      (out_ch.char_code >= ASCII_ZERO && out_ch.char_code <= ASCII_ZERO + 7'd9))
    else $error("character code outside the decimal set");

  // Character count stays within one to eleven
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.char_total != 4'd0 && out_ch.char_total <= 4'd11)
    else $error("character count out of range");

endmodule
